### sv/iee_pkg.sv
package iee_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int RESULT_WIDTH    = 32;
    localparam int CH_WIDTH        = 8;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CH_WIDTH-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_WIDTH-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_WIDTH-1:0] CH_MUL   = 8'h2A;
    localparam logic [CH_WIDTH-1:0] CH_DIV   = 8'h2F;
    localparam logic [CH_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_WIDTH-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        CMD_DIGIT,
        CMD_MUL,
        CMD_DIV,
        CMD_ADD,
        CMD_SUB,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [3:0] digit;
        logic       last;
    } cmd_t;

    typedef enum logic [1:0] {
        TOP_NONE,
        TOP_MUL,
        TOP_DIV
    } term_op_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_EXEC,
        BS_WAIT
    } back_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_RUN,
        MD_FIX
    } md_state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic div_zero;
    } md_rsp_t;

endpackage

### sv/iee_front.sv
module iee_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [iee_pkg::CH_WIDTH-1:0]  s_tdata,
    input  logic                          s_tlast,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output iee_pkg::cmd_t                 cmd
);
    import iee_pkg::*;

    logic       vld_reg;
    logic       vld_next;
    cmd_t       cmd_reg;
    cmd_t       cmd_next;
    logic       accept;
    logic       is_digit;
    logic       keep;

    assign s_tready  = !vld_reg || cmd_ready;
    assign accept    = s_tvalid && s_tready;
    assign cmd_valid = vld_reg;
    assign cmd       = cmd_reg;
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);

    // classify the character; unknown characters only survive to carry the end mark
    always_comb
    begin
        cmd_next       = cmd_reg;
        keep           = 1'b1;
        cmd_next.last  = s_tlast;
        cmd_next.digit = 4'(s_tdata - CH_ZERO);
        if (is_digit)
        begin
            cmd_next.kind = CMD_DIGIT;
        end
        else
        begin
            case (s_tdata)
                CH_MUL:   cmd_next.kind = CMD_MUL;
                CH_DIV:   cmd_next.kind = CMD_DIV;
                CH_PLUS:  cmd_next.kind = CMD_ADD;
                CH_MINUS: cmd_next.kind = CMD_SUB;
                default:
                begin
                    cmd_next.kind = CMD_END;
                    keep          = s_tlast;
                end
            endcase
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
        begin
            vld_next = keep;
        end
        else if (cmd_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

### sv/iee_fifo.sv
module iee_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  iee_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output iee_pkg::cmd_t out_cmd
);
    import iee_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] wr_next;
    logic [QPTR_W-1:0] rd_reg;
    logic [QPTR_W-1:0] rd_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              pop;

    assign in_ready  = cnt_reg < QCNT_W'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end

endmodule

### sv/iee_muldiv.sv
module iee_muldiv #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_pkg::md_req_t       req,
    input  logic [VALUE_WIDTH-1:0] opa,
    input  logic [VALUE_WIDTH-1:0] opb,
    output iee_pkg::md_rsp_t       rsp,
    output logic [VALUE_WIDTH-1:0] quot
);
    import iee_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W);

    md_state_t       st_reg;
    md_state_t       st_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            div_reg;
    logic            div_next;
    logic            neg_reg;
    logic            neg_next;
    logic            dz_reg;
    logic            dz_next;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    rem_next;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    acc_next;
    logic [W-1:0]    x_reg;
    logic [W-1:0]    x_next;
    logic [W-1:0]    y_reg;
    logic [W-1:0]    y_next;
    logic            b_zero;
    logic [W-1:0]    a_mag;
    logic [W-1:0]    b_mag;
    logic [W:0]      rem_sh;
    logic [W:0]      dvs_ext;
    logic [W:0]      rem_sub;
    logic            rem_ge;

    assign b_zero  = opb == '0;
    assign a_mag   = opa[W-1] ? W'(-opa) : opa;
    assign b_mag   = opb[W-1] ? W'(-opb) : opb;
    assign rem_sh  = {rem_reg, x_reg[W-1]};
    assign dvs_ext = {1'b0, y_reg};
    assign rem_ge  = rem_sh >= dvs_ext;
    assign rem_sub = rem_sh - dvs_ext;

    assign rsp.busy     = st_reg != MD_IDLE;
    assign rsp.done     = st_reg == MD_FIX;
    assign rsp.div_zero = dz_reg;
    assign quot         = neg_reg ? W'(-acc_reg) : acc_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    st_next = (req.is_div && b_zero) ? MD_FIX : MD_RUN;
                end
            end
            MD_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    st_next = MD_FIX;
                end
            end
            MD_FIX:  st_next = MD_IDLE;
            default: st_next = MD_IDLE;
        endcase
    end

    // shift-subtract divide on magnitudes, shift-add multiply, one bit per cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        div_next = div_reg;
        neg_next = neg_reg;
        dz_next  = dz_reg;
        rem_next = rem_reg;
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        case (st_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = CW'(W - 1);
                    div_next = req.is_div;
                    dz_next  = req.is_div && b_zero;
                    neg_next = req.is_div && !b_zero && (opa[W-1] ^ opb[W-1]);
                    rem_next = '0;
                    acc_next = '0;
                    x_next   = req.is_div ? a_mag : opa;
                    y_next   = req.is_div ? b_mag : opb;
                end
            end
            MD_RUN:
            begin
                cnt_next = cnt_reg - 1'b1;
                x_next   = {x_reg[W-2:0], 1'b0};
                if (div_reg)
                begin
                    rem_next = rem_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
                    acc_next = {acc_reg[W-2:0], rem_ge};
                end
                else
                begin
                    y_next = {1'b0, y_reg[W-1:1]};
                    if (y_reg[0])
                    begin
                        acc_next = acc_reg + x_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= MD_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
        dz_reg  <= dz_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

endmodule

### sv/iee_back.sv
module iee_back #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  iee_pkg::cmd_t                     cmd,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [iee_pkg::RESULT_WIDTH-1:0]  m_tdata,
    output logic                              m_tuser
);
    import iee_pkg::*;

    localparam int W = VALUE_WIDTH;

    back_state_t             state_reg;
    back_state_t             state_next;
    cmd_t                    cur_reg;
    cmd_t                    cur_next;
    logic [W-1:0]            number_reg;
    logic [W-1:0]            number_next;
    logic [W-1:0]            term_reg;
    logic [W-1:0]            term_next;
    logic [W-1:0]            sum_reg;
    logic [W-1:0]            sum_next;
    term_op_t                term_op_reg;
    term_op_t                term_op_next;
    logic                    add_sign_reg;
    logic                    add_sign_next;
    logic                    div_err_reg;
    logic                    div_err_next;
    logic                    fdone_reg;
    logic                    fdone_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [RESULT_WIDTH-1:0] out_result_reg;
    logic [RESULT_WIDTH-1:0] out_result_next;
    logic                    out_dz_reg;
    logic                    out_dz_next;

    md_req_t                 md_req;
    md_rsp_t                 md_rsp;
    logic [W-1:0]            md_q;

    logic                    pending;
    logic                    out_free;
    logic                    is_digit;
    logic                    is_end;
    logic                    stall;
    logic                    act_done;
    logic                    emit;
    logic [W-1:0]            new_term;
    logic [W-1:0]            total;

    assign cmd_ready = state_reg == BS_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_result_reg;
    assign m_tuser   = out_dz_reg;

    assign pending  = ((term_op_reg == TOP_MUL) || (term_op_reg == TOP_DIV)) && !fdone_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign is_digit = cur_reg.kind == CMD_DIGIT;
    assign is_end   = cur_reg.kind == CMD_END;
    assign stall    = !is_digit && (pending || (is_end && !out_free));
    assign act_done = (state_reg == BS_EXEC) && !stall;
    assign emit     = act_done && is_end;
    assign new_term = fdone_reg ? term_reg : number_reg;
    assign total    = add_sign_reg ? sum_reg - new_term : sum_reg + new_term;

    assign md_req.start  = (state_reg == BS_EXEC) && !is_digit && pending;
    assign md_req.is_div = term_op_reg == TOP_DIV;

    iee_muldiv #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .opa   (term_reg),
        .opb   (number_reg),
        .rsp   (md_rsp),
        .quot  (md_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BS_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BS_EXEC;
                end
            end
            BS_EXEC:
            begin
                if (md_req.start)
                begin
                    state_next = BS_WAIT;
                end
                else if (act_done && !(cur_reg.last && !is_end))
                begin
                    state_next = BS_IDLE;
                end
            end
            BS_WAIT:
            begin
                if (md_rsp.done)
                begin
                    state_next = BS_EXEC;
                end
            end
            default: state_next = BS_IDLE;
        endcase
    end

    always_comb
    begin
        cur_next        = cur_reg;
        number_next     = number_reg;
        term_next       = term_reg;
        sum_next        = sum_reg;
        term_op_next    = term_op_reg;
        add_sign_next   = add_sign_reg;
        div_err_next    = div_err_reg;
        fdone_next      = fdone_reg;
        out_result_next = out_result_reg;
        out_dz_next     = out_dz_reg;
        out_valid_next  = m_tready ? 1'b0 : out_valid_reg;

        if ((state_reg == BS_IDLE) && cmd_valid)
        begin
            cur_next = cmd;
        end

        if ((state_reg == BS_WAIT) && md_rsp.done)
        begin
            term_next    = md_q;
            number_next  = '0;
            fdone_next   = 1'b1;
            div_err_next = div_err_reg || md_rsp.div_zero;
        end

        if (act_done)
        begin
            // last character done: run the closing step next
            if (cur_reg.last && !is_end)
            begin
                cur_next.kind = CMD_END;
            end
            if (!is_digit)
            begin
                number_next = '0;
                fdone_next  = 1'b0;
            end
            case (cur_reg.kind)
                CMD_DIGIT:
                begin
                    number_next = (number_reg << 3) + (number_reg << 1)
                                + {{(W-4){1'b0}}, cur_reg.digit};
                end
                CMD_MUL:
                begin
                    term_next    = new_term;
                    term_op_next = TOP_MUL;
                end
                CMD_DIV:
                begin
                    term_next    = new_term;
                    term_op_next = TOP_DIV;
                end
                CMD_ADD, CMD_SUB:
                begin
                    sum_next      = total;
                    term_next     = '0;
                    term_op_next  = TOP_NONE;
                    add_sign_next = cur_reg.kind == CMD_SUB;
                end
                CMD_END:
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = RESULT_WIDTH'($signed(total));
                    out_dz_next     = div_err_reg;
                    sum_next        = '0;
                    term_next       = '0;
                    term_op_next    = TOP_NONE;
                    add_sign_next   = 1'b0;
                    div_err_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            number_reg    <= '0;
            term_reg      <= '0;
            sum_reg       <= '0;
            term_op_reg   <= TOP_NONE;
            add_sign_reg  <= 1'b0;
            div_err_reg   <= 1'b0;
            fdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            number_reg    <= number_next;
            term_reg      <= term_next;
            sum_reg       <= sum_next;
            term_op_reg   <= term_op_next;
            add_sign_reg  <= add_sign_next;
            div_err_reg   <= div_err_next;
            fdone_reg     <= fdone_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        out_result_reg <= out_result_next;
        out_dz_reg     <= out_dz_next;
    end

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        md_req.start |-> !md_rsp.busy)
        else $error("muldiv started while busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> state_reg == BS_WAIT)
        else $error("muldiv result with no waiting operator");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("result lost at end of expression");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (sum_reg == '0) && !div_err_reg && (term_op_reg == TOP_NONE))
        else $error("state not cleared after result");
`endif

endmodule

### sv/infix_expression_evaluator_top.sv
// Infix integer expression evaluator. Characters arrive one per request on the
// s_ side (digits and + - * /, other characters ignored, s_tlast on the final
// one); one result comes out on the m_ side per expression: the value with
// usual precedence, computed at VALUE_WIDTH bits with wrap-around and given as
// 32 bits, plus a sticky divide-by-zero flag in m_tuser (quotient then 0).
// The front stage classifies a character and queues it, so the
// input runs ahead of evaluation by up to three characters. The evaluator
// takes no new character before it is through with the last; an operator (or
// the end) that closes a pending * or / runs the shared shift-add /
// shift-subtract unit, one bit per cycle. The end of an expression runs as a
// closing step of its own, unless the final character is an ignored one, which
// then carries that step.
module infix_expression_evaluator_top #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [iee_pkg::CH_WIDTH-1:0]      s_tdata,   // ch
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [iee_pkg::RESULT_WIDTH-1:0]  m_tdata,   // result
    output logic                              m_tuser    // div_by_zero
);
    import iee_pkg::*;

    logic fe_valid;
    logic fe_ready;
    cmd_t fe_cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;

    iee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd)
    );

    iee_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_cmd    (fe_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    iee_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
